// ===== hdl/tels_pkg.sv =====
// ----------------------------------------------------------------------------
// Tab expansion line streamer package
// Shared widths, register indexes, character codes and default limits.
// ----------------------------------------------------------------------------
package tels_pkg;

  // Field widths of the request and result channels.
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 13;
  localparam int TABW_W = 6;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TAB_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINTABLE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINTABLE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_CAPACITY  = 3'd4;

  // Register reset values.
  localparam logic              TAB_ENABLE_RST     = 1'b1;
  localparam logic [TABW_W-1:0] TAB_WIDTH_RST      = 6'd8;
  localparam logic [CHAR_W-1:0] PRINTABLE_LOW_RST  = 8'd32;
  localparam logic [CHAR_W-1:0] PRINTABLE_HIGH_RST = 8'd126;
  localparam logic [LEN_W-1:0]  LINE_CAPACITY_RST  = 13'd256;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // Default limits.
  localparam int MAX_CAPACITY_DEF = 4096;
  localparam int MAX_TAB_DEF      = 32;

endpackage

// ===== hdl/tab_expand_line_stream.sv =====
// ----------------------------------------------------------------------------
// Tab expansion line streamer
// Expands tabs to tab stops, filters nonprintable bytes and limits the
// expanded length of each line.
// ----------------------------------------------------------------------------
// Each accepted request is decoded, then gives its results one per cycle
// while the output register can take them: one for an ordinary character,
// spaces up to the next tab stop for a tab (at most MAX_TAB, and no more
// than the room left), under a two-state sequencer with a decrementing
// column counter and a room counter. A request that gives no result (a
// character after the line is full, without line_end) leaves the block
// idle. Results are held in an output register, so a new request may be
// accepted while the last result still waits to be taken.
module tab_expand_line_stream #(
  parameter int MAX_CAPACITY = tels_pkg::MAX_CAPACITY_DEF,
  parameter int MAX_TAB      = tels_pkg::MAX_TAB_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [tels_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tels_pkg::CFG_W-1:0]        cfg_data,
  // Character requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tels_pkg::CHAR_W-1:0] char_in,
  input  logic                              line_start,
  input  logic                              line_end,
  // Display results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tels_pkg::CHAR_W-1:0]       char_out,
  output logic                              run_last,
  output logic                              line_done,
  output logic [tels_pkg::LEN_W-1:0]        expanded_length,
  output logic                              capacity_hit
);
  import tels_pkg::*;

  localparam int CW = $clog2(MAX_CAPACITY + 1);
  localparam int TW = $clog2(MAX_TAB + 1);
  localparam int CAP_RST = (256 > MAX_CAPACITY) ? MAX_CAPACITY : 256;
  localparam int TAB_RST = (8 > MAX_TAB) ? MAX_TAB : 8;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // Configuration registers.
  logic                     tab_enable;
  logic [TABW_W-1:0]        tab_width;
  logic signed [CHAR_W-1:0] printable_low;
  logic signed [CHAR_W-1:0] printable_high;
  logic [LEN_W-1:0]         line_capacity;

  // Line state and sequencer.
  logic              state, state_next;
  logic [CW-1:0]     room_left, room_left_next;
  logic [CW-1:0]     cap_latched, cap_latched_next;
  logic [TW-1:0]     tab_countdown, tab_countdown_next;
  logic              full_flag, full_flag_next;
  logic [TW-1:0]     count, count_next;
  logic [CHAR_W-1:0] emit_char, emit_char_next;
  logic              emit_status, emit_status_next;
  logic              end_flag, end_flag_next;

  // Output register.
  logic              out_valid_next;
  logic [CHAR_W-1:0] char_out_next;
  logic              run_last_next;
  logic              line_done_next;
  logic [LEN_W-1:0]  expanded_length_next;
  logic              capacity_hit_next;

  logic [TW-1:0] eff_tab;
  logic [CW-1:0] eff_cap;
  logic [CW-1:0] room_s;
  logic [CW-1:0] cap_s;
  logic [TW-1:0] cd_s;
  logic          full_s;
  logic [TW-1:0] tab_run;
  logic          slot_free;
  logic          accept;
  logic [CW-1:0] room_dec;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_enable     <= TAB_ENABLE_RST;
      tab_width      <= TAB_WIDTH_RST;
      printable_low  <= PRINTABLE_LOW_RST;
      printable_high <= PRINTABLE_HIGH_RST;
      line_capacity  <= LINE_CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAB_ENABLE:     tab_enable     <= cfg_data[0];
        REG_TAB_WIDTH:      tab_width      <= cfg_data[TABW_W-1:0];
        REG_PRINTABLE_LOW:  printable_low  <= cfg_data[CHAR_W-1:0];
        REG_PRINTABLE_HIGH: printable_high <= cfg_data[CHAR_W-1:0];
        REG_LINE_CAPACITY:  line_capacity  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp tab width and capacity into their supported ranges.
  always_comb begin
    if (tab_width == '0) begin
      eff_tab = TW'(1);
    end else if (32'(tab_width) > 32'(MAX_TAB)) begin
      eff_tab = TW'(MAX_TAB);
    end else begin
      eff_tab = TW'(tab_width);
    end
    if (line_capacity == '0) begin
      eff_cap = CW'(1);
    end else if (32'(line_capacity) > 32'(MAX_CAPACITY)) begin
      eff_cap = CW'(MAX_CAPACITY);
    end else begin
      eff_cap = CW'(line_capacity);
    end
  end

  // Line counters as seen by the incoming request, after a line start.
  always_comb begin
    room_s = line_start ? eff_cap : room_left;
    cap_s  = line_start ? eff_cap : cap_latched;
    cd_s   = line_start ? eff_tab : tab_countdown;
    full_s = line_start ? 1'b0 : full_flag;
    tab_run = cd_s;
    if (cd_s == '0 || 32'(cd_s) > 32'(MAX_TAB)) begin
      tab_run = eff_tab;
    end
    if (32'(tab_run) > 32'(room_s)) begin
      tab_run = TW'(room_s);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign room_dec  = room_left - CW'(1);

  // Sequencer: decode a request, then emit its results one per cycle while the output slot is free.
  always_comb begin
    state_next           = state;
    room_left_next       = room_left;
    cap_latched_next     = cap_latched;
    tab_countdown_next   = tab_countdown;
    full_flag_next       = full_flag;
    count_next           = count;
    emit_char_next       = emit_char;
    emit_status_next     = emit_status;
    end_flag_next        = end_flag;
    out_valid_next       = out_valid && !out_ready;
    char_out_next        = char_out;
    run_last_next        = run_last;
    line_done_next       = line_done;
    expanded_length_next = expanded_length;
    capacity_hit_next    = capacity_hit;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          room_left_next     = room_s;
          cap_latched_next   = cap_s;
          tab_countdown_next = cd_s;
          full_flag_next     = full_s;
          end_flag_next      = line_end;
          emit_status_next   = 1'b0;
          if (!full_s) begin
            state_next = ST_EMIT;
            if (tab_enable && char_in == CHAR_TAB) begin
              count_next         = tab_run;
              emit_char_next     = CHAR_SPACE;
              tab_countdown_next = eff_tab;
            end else begin
              count_next = TW'(1);
              if (char_in < printable_low || char_in > printable_high) begin
                emit_char_next = CHAR_SPACE;
              end else begin
                emit_char_next = char_in;
              end
              if (tab_enable) begin
                if (cd_s <= TW'(1) || 32'(cd_s) > 32'(MAX_TAB)) begin
                  tab_countdown_next = eff_tab;
                end else begin
                  tab_countdown_next = cd_s - TW'(1);
                end
              end
            end
          end else if (line_end) begin
            // Full line closed: one status result only.
            state_next       = ST_EMIT;
            count_next       = TW'(1);
            emit_char_next   = CHAR_NUL;
            emit_status_next = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          run_last_next  = (count == TW'(1));
          line_done_next = (count == TW'(1)) && end_flag;
          char_out_next  = emit_char;
          if (emit_status) begin
            expanded_length_next = LEN_W'(cap_latched - room_left);
            capacity_hit_next    = full_flag;
          end else begin
            room_left_next       = room_dec;
            expanded_length_next = LEN_W'(cap_latched - room_dec);
            capacity_hit_next    = (room_dec == '0);
            if (room_dec == '0) begin
              full_flag_next = 1'b1;
            end
          end
          count_next = count - TW'(1);
          if (count == TW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      room_left     <= CW'(CAP_RST);
      cap_latched   <= CW'(CAP_RST);
      tab_countdown <= TW'(TAB_RST);
      full_flag     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      room_left     <= room_left_next;
      cap_latched   <= cap_latched_next;
      tab_countdown <= tab_countdown_next;
      full_flag     <= full_flag_next;
      out_valid     <= out_valid_next;
    end
  end

  // Job and result payload.
  always_ff @(posedge clk) begin
    count           <= count_next;
    emit_char       <= emit_char_next;
    emit_status     <= emit_status_next;
    end_flag        <= end_flag_next;
    char_out        <= char_out_next;
    run_last        <= run_last_next;
    line_done       <= line_done_next;
    expanded_length <= expanded_length_next;
    capacity_hit    <= capacity_hit_next;
  end

endmodule
